// ----- design/mwmf_pkg.sv -----
package mwmf_pkg;

  localparam int MAX_WIDTH_DEF   = 512;
  localparam int MAX_RADIUS_DEF  = 7;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_HEIGHT      = 512;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int RAD_W      = 4;
  localparam int RING_MAX_W = 5;
  localparam int CNT_W      = 8;
  localparam int MEAN_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [MEAN_W-1:0] MEAN_MAX = 15'h7FFF;

  typedef struct packed {
    logic [COL_W-1:0] width;
    logic [ROW_W-1:0] height;
    logic [RAD_W-1:0] radius;
  } geom_t;

  typedef struct packed {
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [RING_MAX_W-1:0] ring;
    logic                  last;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CENTER,
    B_CHECK,
    B_SCAN,
    B_TAIL,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

// ----- design/mwmf_line_store.sv -----
module mwmf_line_store #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/mwmf_front.sv -----
module mwmf_front #(
  parameter int MAX_WIDTH   = mwmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS  = mwmf_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = mwmf_pkg::SAMPLE_BITS_DEF,
  localparam int LINE_ROWS  = 2 * MAX_RADIUS + 2,
  localparam int RING_W     = $clog2(LINE_ROWS),
  localparam int ADDR_W     = $clog2(LINE_ROWS * MAX_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mwmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mwmf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [15:0]                         in_pixel,
  output logic                                wr_en,
  output logic [ADDR_W-1:0]                   wr_addr,
  output logic [SAMPLE_BITS-1:0]              wr_data,
  output mwmf_pkg::geom_t                     geom,
  output logic                                job_valid,
  output mwmf_pkg::job_t                      job,
  input  logic                                job_ready,
  input  logic                                slice_done
);

  localparam int CW = mwmf_pkg::COL_W;
  localparam int RW = mwmf_pkg::ROW_W;

  logic [9:0]        width_r, width_nxt, height_r, height_nxt;
  logic [2:0]        radius_r, radius_nxt;
  logic [CW-1:0]     in_col_r, in_col_nxt, in_col_a;
  logic [RW-1:0]     in_row_r, in_row_nxt, in_row_a;
  logic [RING_W-1:0] in_ring_r, in_ring_nxt, in_ring_a;
  logic              in_done_r, in_done_nxt, in_done_a;
  logic [CW-1:0]     out_col_r, out_col_nxt;
  logic [RW-1:0]     out_row_r, out_row_nxt;
  logic [RING_W-1:0] out_ring_r, out_ring_nxt;
  logic              job_valid_r, job_valid_nxt;
  mwmf_pkg::job_t    job_r, job_nxt;
  logic              hold_r, hold_nxt;

  logic [CW-1:0]     eff_w;
  logic [RW-1:0]     eff_h;
  logic [3:0]        eff_r;
  logic [RW-1:0]     need_row;
  logic [CW-1:0]     need_col;
  logic              accept, store, ready, last, fire;
  logic [SAMPLE_BITS+15:0] pix_ext;

  always_comb begin
    if (width_r == 10'd0) begin
      eff_w = 10'd1;
    end else if ({3'b0, width_r} > 13'(MAX_WIDTH)) begin
      eff_w = 10'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == 10'd0) begin
      eff_h = 10'd1;
    end else if (height_r > 10'(mwmf_pkg::MAX_HEIGHT)) begin
      eff_h = 10'(mwmf_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
    if ({1'b0, radius_r} > 4'(MAX_RADIUS)) begin
      eff_r = 4'(MAX_RADIUS);
    end else begin
      eff_r = {1'b0, radius_r};
    end
  end

  assign geom = '{width: eff_w, height: eff_h, radius: eff_r};

  assign in_ready = !job_valid_r && !hold_r;
  assign accept   = in_valid && in_ready;
  assign store    = accept && !in_mode && !in_done_r;

  assign pix_ext = {{SAMPLE_BITS{1'b0}}, in_pixel};
  assign wr_en   = store;
  assign wr_data = pix_ext[SAMPLE_BITS-1:0];
  assign wr_addr = ADDR_W'(32'(in_ring_r) * 32'(MAX_WIDTH) + 32'(in_col_r));

  always_comb begin
    in_col_a  = in_col_r;
    in_row_a  = in_row_r;
    in_ring_a = in_ring_r;
    in_done_a = in_done_r;
    if (store) begin
      if ({1'b0, in_col_r} + 11'd1 >= {1'b0, eff_w}) begin
        in_col_a = '0;
        if ({1'b0, in_row_r} + 11'd1 >= {1'b0, eff_h}) begin
          in_row_a  = '0;
          in_ring_a = '0;
          in_done_a = 1'b1;
        end else begin
          in_row_a  = in_row_r + 10'd1;
          in_ring_a = (32'(in_ring_r) == LINE_ROWS - 1) ? '0 : in_ring_r + 1'b1;
        end
      end else begin
        in_col_a = in_col_r + 10'd1;
      end
    end
  end

  always_comb begin
    if ({1'b0, out_row_r} + 11'(eff_r) > {1'b0, eff_h} - 11'd1) begin
      need_row = eff_h - 10'd1;
    end else begin
      need_row = out_row_r + 10'(eff_r);
    end
    if ({1'b0, out_col_r} + 11'(eff_r) > {1'b0, eff_w} - 11'd1) begin
      need_col = eff_w - 10'd1;
    end else begin
      need_col = out_col_r + 10'(eff_r);
    end
    ready = in_done_a || (in_row_a > need_row) ||
            ((in_row_a == need_row) && (in_col_a > need_col));
    last  = (out_row_r == eff_h - 10'd1) && (out_col_r == eff_w - 10'd1);
    fire  = accept && ready;
  end

  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    radius_nxt    = radius_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    in_ring_nxt   = in_ring_r;
    in_done_nxt   = in_done_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_ring_nxt  = out_ring_r;
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r && !job_ready;
    hold_nxt      = hold_r && !slice_done;
    if (cfg_we && (cfg_index == mwmf_pkg::REG_WIDTH || cfg_index == mwmf_pkg::REG_HEIGHT ||
                   cfg_index == mwmf_pkg::REG_RADIUS)) begin
      case (cfg_index)
        mwmf_pkg::REG_WIDTH:  width_nxt  = cfg_data;
        mwmf_pkg::REG_HEIGHT: height_nxt = cfg_data;
        default:              radius_nxt = cfg_data[2:0];
      endcase
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_ring_nxt  = '0;
      in_done_nxt  = 1'b0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_ring_nxt = '0;
    end else if (accept) begin
      in_col_nxt  = in_col_a;
      in_row_nxt  = in_row_a;
      in_ring_nxt = in_ring_a;
      in_done_nxt = in_done_a;
      if (fire) begin
        job_valid_nxt = 1'b1;
        job_nxt = '{row: out_row_r, col: out_col_r,
                    ring: mwmf_pkg::RING_MAX_W'(out_ring_r), last: last};
        if (last) begin
          hold_nxt     = 1'b1;
          in_col_nxt   = '0;
          in_row_nxt   = '0;
          in_ring_nxt  = '0;
          in_done_nxt  = 1'b0;
          out_col_nxt  = '0;
          out_row_nxt  = '0;
          out_ring_nxt = '0;
        end else if ({1'b0, out_col_r} + 11'd1 >= {1'b0, eff_w}) begin
          out_col_nxt  = '0;
          out_row_nxt  = out_row_r + 10'd1;
          out_ring_nxt = (32'(out_ring_r) == LINE_ROWS - 1) ? '0 : out_ring_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 10'd512;
      height_r    <= 10'd512;
      radius_r    <= 3'd1;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_ring_r   <= '0;
      in_done_r   <= 1'b0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_ring_r  <= '0;
      job_valid_r <= 1'b0;
      hold_r      <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      radius_r    <= radius_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      in_ring_r   <= in_ring_nxt;
      in_done_r   <= in_done_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_ring_r  <= out_ring_nxt;
      job_valid_r <= job_valid_nxt;
      hold_r      <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

// ----- design/mwmf_back.sv -----
module mwmf_back #(
  parameter int MAX_WIDTH   = mwmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS  = mwmf_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = mwmf_pkg::SAMPLE_BITS_DEF,
  localparam int LINE_ROWS  = 2 * MAX_RADIUS + 2,
  localparam int RING_W     = $clog2(LINE_ROWS),
  localparam int ADDR_W     = $clog2(LINE_ROWS * MAX_WIDTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mwmf_pkg::geom_t                geom,
  input  logic                           job_valid,
  input  mwmf_pkg::job_t                 job,
  output logic                           job_ready,
  output logic [ADDR_W-1:0]              rd_addr,
  input  logic [SAMPLE_BITS-1:0]         rd_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mwmf_pkg::MEAN_W-1:0]    out_mean,
  output logic                           out_last,
  output logic                           slice_done
);

  localparam int CW    = mwmf_pkg::COL_W;
  localparam int RW    = mwmf_pkg::ROW_W;
  localparam int NW    = mwmf_pkg::CNT_W;
  localparam int SUM_W = SAMPLE_BITS + NW - 1;
  localparam int DC_W  = $clog2(SUM_W + 1);

  mwmf_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0]     col_r, x_r, c0_r, c1_r;
  logic [RW-1:0]     y_r, y1_r;
  logic [RING_W-1:0] ring_r, yring_r;
  logic              last_r, acc_en_r;
  logic [SUM_W-1:0]  sum_r;
  logic [NW-1:0]     cnt_r, rem_r;
  logic [DC_W-1:0]   div_cnt_r;
  logic [mwmf_pkg::MEAN_W-1:0] mean_r;

  logic [RW-1:0]     j_r0, j_dr, j_y1;
  logic [CW-1:0]     j_c0, j_c1;
  logic [RING_W-1:0] j_ring, j_ring0;
  logic [RING_W:0]   ring_wide;
  logic              data_pos, scan_end, div_ge;
  logic [NW:0]       div_t;
  logic [SUM_W-1:0]  quo_nxt;
  logic [SUM_W+15:0] quo_ext;

  function automatic logic positive(input logic [SAMPLE_BITS-1:0] s);
    positive = !s[SAMPLE_BITS-1] && (|s);
  endfunction

  assign data_pos = positive(rd_data);

  always_comb begin
    j_ring = RING_W'(job.ring);
    j_r0   = (job.row >= 10'(geom.radius)) ? job.row - 10'(geom.radius) : '0;
    j_dr   = job.row - j_r0;
    ring_wide = {1'b0, j_ring} + (RING_W+1)'(LINE_ROWS) - (RING_W+1)'(j_dr);
    j_ring0 = ({1'b0, j_ring} >= (RING_W+1)'(j_dr)) ? j_ring - RING_W'(j_dr) :
              ring_wide[RING_W-1:0];
    if ({1'b0, job.row} + 11'(geom.radius) > {1'b0, geom.height} - 11'd1) begin
      j_y1 = geom.height - 10'd1;
    end else begin
      j_y1 = job.row + 10'(geom.radius);
    end
    j_c0 = (job.col >= 10'(geom.radius)) ? job.col - 10'(geom.radius) : '0;
    if ({1'b0, job.col} + 11'(geom.radius) > {1'b0, geom.width} - 11'd1) begin
      j_c1 = geom.width - 10'd1;
    end else begin
      j_c1 = job.col + 10'(geom.radius);
    end
  end

  assign scan_end = (x_r == c1_r) && (y_r == y1_r);

  always_comb begin
    div_t   = {rem_r, sum_r[SUM_W-1]};
    div_ge  = div_t >= {1'b0, cnt_r};
    quo_nxt = {sum_r[SUM_W-2:0], div_ge};
    quo_ext = {16'd0, quo_nxt};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mwmf_pkg::B_IDLE:   if (job_valid) state_nxt = mwmf_pkg::B_CENTER;
      mwmf_pkg::B_CENTER: state_nxt = mwmf_pkg::B_CHECK;
      mwmf_pkg::B_CHECK:  state_nxt = data_pos ? mwmf_pkg::B_SCAN : mwmf_pkg::B_OUT;
      mwmf_pkg::B_SCAN:   if (scan_end) state_nxt = mwmf_pkg::B_TAIL;
      mwmf_pkg::B_TAIL:   state_nxt = mwmf_pkg::B_DIV;
      mwmf_pkg::B_DIV:    if (div_cnt_r == DC_W'(1)) state_nxt = mwmf_pkg::B_OUT;
      mwmf_pkg::B_OUT:    if (out_ready) state_nxt = mwmf_pkg::B_IDLE;
      default:            state_nxt = mwmf_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_ready = 1'b0;
    rd_addr   = ADDR_W'(32'(ring_r) * 32'(MAX_WIDTH) + 32'(col_r));
    case (state_r)
      mwmf_pkg::B_IDLE: job_ready = job_valid;
      mwmf_pkg::B_SCAN: rd_addr = ADDR_W'(32'(yring_r) * 32'(MAX_WIDTH) + 32'(x_r));
      default: ;
    endcase
  end

  assign out_valid  = (state_r == mwmf_pkg::B_OUT);
  assign out_mean   = mean_r;
  assign out_last   = last_r;
  assign slice_done = out_valid && out_ready && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mwmf_pkg::B_IDLE;
      acc_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_en_r <= (state_r == mwmf_pkg::B_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mwmf_pkg::B_IDLE: begin
        col_r   <= job.col;
        ring_r  <= j_ring;
        last_r  <= job.last;
        y_r     <= j_r0;
        yring_r <= j_ring0;
        y1_r    <= j_y1;
        x_r     <= j_c0;
        c0_r    <= j_c0;
        c1_r    <= j_c1;
      end
      mwmf_pkg::B_CHECK: begin
        sum_r  <= '0;
        cnt_r  <= '0;
        mean_r <= '0;
      end
      mwmf_pkg::B_SCAN: begin
        if (x_r == c1_r) begin
          x_r     <= c0_r;
          y_r     <= y_r + 10'd1;
          yring_r <= (32'(yring_r) == LINE_ROWS - 1) ? '0 : yring_r + 1'b1;
        end else begin
          x_r <= x_r + 10'd1;
        end
      end
      mwmf_pkg::B_TAIL: begin
        div_cnt_r <= DC_W'(SUM_W);
        rem_r     <= '0;
      end
      mwmf_pkg::B_DIV: begin
        sum_r     <= quo_nxt;
        rem_r     <= div_ge ? NW'(div_t - {1'b0, cnt_r}) : div_t[NW-1:0];
        div_cnt_r <= div_cnt_r - 1'b1;
        mean_r    <= (quo_ext > (SUM_W+16)'(mwmf_pkg::MEAN_MAX)) ? mwmf_pkg::MEAN_MAX :
                     quo_ext[mwmf_pkg::MEAN_W-1:0];
      end
      default: ;
    endcase
    if (acc_en_r && data_pos) begin
      sum_r <= sum_r + SUM_W'(rd_data);
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

// ----- design/masked_window_mean_filter.sv -----
// Masked box mean filter: pixels of each slice enter in raster order on the in_ stream
// (tuser high marks a flush tick), and every result is the truncated mean of the positive
// pixels in a square window around it, 0 where the centre is not positive, with tlast on
// the final result of a slice. A result whose centre is not positive skips the window
// scan; otherwise its clipped window of up to 225 pixels is scanned through the single read
// port of the line store, one window pixel a cycle, and a bit-serial divider then gives one
// quotient bit a cycle. Items with no result are taken one a cycle while the front is ready.
// While one result is computed the front takes items until one more result is queued;
// after the last result of a slice it waits until that result has been delivered.
module masked_window_mean_filter #(
  parameter int MAX_WIDTH   = mwmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS  = mwmf_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = mwmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // pixel_value
  input  logic [0:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // mean_value, zero
  output logic        out_tlast
);

  localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int DEPTH     = LINE_ROWS * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(DEPTH);

  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] wr_data, rd_data;
  mwmf_pkg::geom_t        geom;
  mwmf_pkg::job_t         job;
  logic                   job_valid, job_ready, slice_done;
  logic [mwmf_pkg::MEAN_W-1:0] mean;

  mwmf_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_mode(in_tuser[0]),
    .in_pixel(in_tdata), .wr_en, .wr_addr, .wr_data, .geom,
    .job_valid, .job, .job_ready, .slice_done
  );

  mwmf_line_store #(.DATA_W(SAMPLE_BITS), .DEPTH(DEPTH)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  mwmf_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk, .rst_n, .geom, .job_valid, .job, .job_ready, .rd_addr, .rd_data,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_mean(mean),
    .out_last(out_tlast), .slice_done
  );

  assign out_tdata = {1'b0, mean};

endmodule

// ----- design/mwmf_checker.sv -----
module mwmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [9:0]  cfg_data,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[15])
    else $error("mean above 15 bits");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("result right after slice end");

endmodule

bind masked_window_mean_filter mwmf_checker u_mwmf_checker (.*);
